[hw/rtl/assert_macros.svh]
// Assertion macros shared by the rectangular-to-polar converter.
// Depends on nothing; included by the top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked in the next cycle, disabled during reset.
`define ASSERT_NEXT(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
	else $error("assertion failed");
// Implication checked in the same cycle, disabled during reset.
`define ASSERT_SAME(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
	else $error("assertion failed");
`endif

[hw/rtl/r2p_pkg.sv]
// Types, constants and helpers for the rectangular-to-polar converter.
// Depends on nothing.
package r2p_pkg;
	localparam int CoordBits = 16;
	localparam int AbsBits = CoordBits;
	localparam int SqBits = 2 * AbsBits + 1;
	localparam int RootBits = AbsBits + 1;
	localparam int RatioBits = 16;
	localparam int RBits = RatioBits + 1;
	localparam int QuotBits = RBits;
	localparam int DivCells = RBits;
	localparam int SqrtCells = RootBits;
	localparam int AngleFracBits = 13;
	localparam int PolyFrac = 30;
	localparam int PBits = 34;
	localparam int AccBits = 36;
	localparam int Depth = 26;
	localparam int DivStart = 2;
	localparam int PolyStart = DivStart + DivCells;
	localparam int PolySteps = 6;

	localparam logic signed [PBits-1:0] CoefC5 = -34'sd49925210;
	localparam logic signed [PBits-1:0] CoefC3 = 34'sd171062341;
	localparam logic signed [PBits-1:0] CoefC1 = -34'sd351782264;
	localparam logic signed [AccBits-1:0] HalfPi = 36'sd1686629759;
	localparam logic signed [AccBits-1:0] Pi = 36'sd3373259519;

	typedef struct packed {
		logic signed [CoordBits-1:0] x_coord;
		logic signed [CoordBits-1:0] y_coord;
	} point_t;

	typedef struct packed {
		logic [15:0] magnitude;
		logic signed [15:0] angle;
	} polar_t;

	// Octant folding flags carried alongside the data.
	typedef struct packed {
		logic zero;
		logic swap;
		logic xneg;
		logic yneg;
	} fold_t;

	// Square-root cell state: remainder, partial root.
	typedef struct packed {
		logic [SqBits-1:0] rad;
		logic [RootBits-1:0] root;
	} sqrt_t;

	// Divider cell state.
	typedef struct packed {
		logic [AbsBits:0] part;
		logic [AbsBits-1:0] den;
		logic [QuotBits-1:0] quo;
	} div_t;

	// Multiply by s or r in Q.16 and round to nearest, ties away from zero.
	function automatic logic signed [PBits-1:0] mul_round(
		input logic signed [PBits-1:0] p, input logic [RBits-1:0] m);
		logic signed [PBits+RBits:0] prod;
		logic [PBits+RBits:0] mag;
		logic [PBits+RBits:0] res;
		prod = p * $signed({1'b0, m});
		mag = prod[PBits+RBits] ? -prod : prod;
		res = (mag + (1 << (RatioBits - 1))) >> RatioBits;
		mul_round = prod[PBits+RBits] ? -res[PBits-1:0] : res[PBits-1:0];
	endfunction
endpackage

[hw/rtl/r2p_sqrt_cell.sv]
// One restoring square-root cell: settles one root bit per cycle.
// Depends on r2p_pkg.
module r2p_sqrt_cell import r2p_pkg::*; (
	input  logic clk,
	input  logic [4:0] bit_idx,
	input  sqrt_t in_d,
	output sqrt_t out_q
);
	logic [SqBits-1:0] trial;
	logic [SqBits-1:0] b2;

	// Trial subtraction of (2*root + 1) shifted to this bit position.
	always_comb begin
		b2 = SqBits'(1) << (2 * bit_idx);
		trial = (SqBits'(in_d.root) << (bit_idx + 5'd1)) + b2;
	end

	always_ff @(posedge clk) begin
		if (in_d.rad >= trial) begin
			out_q.rad <= in_d.rad - trial;
			out_q.root <= in_d.root | (RootBits'(1) << bit_idx);
		end else begin
			out_q <= in_d;
		end
	end
endmodule

[hw/rtl/r2p_div_cell.sv]
// One restoring divider cell: produces one quotient bit per cycle.
// Depends on r2p_pkg.
module r2p_div_cell import r2p_pkg::*; (
	input  logic clk,
	input  div_t in_d,
	output div_t out_q
);
	logic [AbsBits:0] diff;
	logic take;

	// Try the denominator against the partial remainder.
	always_comb begin
		take = in_d.part >= {1'b0, in_d.den};
		diff = take ? in_d.part - {1'b0, in_d.den} : in_d.part;
	end

	// Hand on the remainder, doubled for the next bit, and the new quotient bit.
	always_ff @(posedge clk) begin
		out_q.den <= in_d.den;
		out_q.part <= {diff[AbsBits-1:0], 1'b0};
		out_q.quo <= {in_d.quo[QuotBits-2:0], take};
	end
endmodule

[hw/rtl/rect_to_polar_converter.sv]
// Top level of the rectangular-to-polar converter.
// Depends on r2p_pkg, r2p_sqrt_cell, r2p_div_cell and assert_macros.svh.
//
// One point is taken in every cycle and its result appears with one strobe per
// request; busy is always low. The path is one setup stage after the accepting
// edge, the row of 17 divider cells for the ratio, five polynomial stages and
// two stages for folding and rounding; the 17 square-root cells run alongside.
// The receiver cannot stall, so results must be consumed on the strobe.
`include "assert_macros.svh"
module rect_to_polar_converter import r2p_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  point_t point,
	output logic done,
	output polar_t result
);
	logic [Depth-1:0] vld_q;
	logic [AbsBits-1:0] ax_s1, ay_s1;
	fold_t fold_s1;
	sqrt_t sq_d [SqrtCells+1];
	div_t dv_d [DivCells+1];
	fold_t fold_q [Depth];
	logic [RootBits-1:0] root_q [Depth];
	logic [RBits-1:0] r_q [PolySteps+1];
	logic signed [PBits-1:0] p_q;
	logic signed [AccBits-1:0] a_q;
	logic [15:0] mag_q;
	logic signed [15:0] ang_q;
	logic [AbsBits-1:0] mn, mx;
	logic [RBits-1:0] rq;
	logic [2*RBits-1:0] rr;
	logic signed [AccBits-1:0] f0, f1, f2, f3;
	logic signed [AccBits-1:0] arnd;

	assign busy = 1'b0;

	// Valid shift line.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[Depth-2:0], start};
		end
	end

	// Stage 1: absolute values and octant flags.
	always_ff @(posedge clk) begin
		ax_s1 <= point.x_coord[CoordBits-1] ? AbsBits'(-point.x_coord) : point.x_coord;
		ay_s1 <= point.y_coord[CoordBits-1] ? AbsBits'(-point.y_coord) : point.y_coord;
		fold_s1.xneg <= point.x_coord[CoordBits-1];
		fold_s1.yneg <= point.y_coord[CoordBits-1];
		fold_s1.zero <= (point.x_coord == '0) && (point.y_coord == '0);
		fold_s1.swap <= 1'b0;
	end

	// Stage 2: feed square root and divider rows.
	assign mn = (ax_s1 < ay_s1) ? ax_s1 : ay_s1;
	assign mx = (ax_s1 < ay_s1) ? ay_s1 : ax_s1;
	always_ff @(posedge clk) begin
		sq_d[0].rad <= SqBits'(ax_s1) * SqBits'(ax_s1) + SqBits'(ay_s1) * SqBits'(ay_s1);
		sq_d[0].root <= '0;
		dv_d[0].part <= {1'b0, mn};
		dv_d[0].den <= (mx == '0) ? AbsBits'(1) : mx;
		dv_d[0].quo <= '0;
		fold_q[0] <= '{zero: fold_s1.zero, swap: ay_s1 > ax_s1,
			xneg: fold_s1.xneg, yneg: fold_s1.yneg};
	end

	// Square-root row, most significant root bit first.
	for (genvar i = 0; i < SqrtCells; i++) begin : g_sqrt
		r2p_sqrt_cell u_cell (
			.clk(clk), .bit_idx(5'(SqrtCells - 1 - i)), .in_d(sq_d[i]), .out_q(sq_d[i+1])
		);
	end

	// Divider row: quotient of min*2^16 by max.
	for (genvar i = 0; i < DivCells; i++) begin : g_div
		r2p_div_cell u_cell (.clk(clk), .in_d(dv_d[i]), .out_q(dv_d[i+1]));
	end

	// Side lines for flags and the root, which finishes on the same cycle as r.
	always_ff @(posedge clk) begin
		for (int k = 1; k < Depth; k++) begin
			fold_q[k] <= fold_q[k-1];
			if (k != PolyStart - DivStart)
				root_q[k] <= root_q[k-1];
		end
		root_q[0] <= '0;
		root_q[PolyStart - DivStart] <= sq_d[SqrtCells].root;
	end

	// Polynomial steps: s, c5*s+c3, *s+c1, *s, *r, fold.
	assign rq = dv_d[DivCells].quo;
	assign rr = rq * rq;
	always_ff @(posedge clk) begin
		r_q[0] <= rq;
		for (int k = 1; k <= PolySteps; k++) r_q[k] <= r_q[k-1];
	end
	logic [RBits-1:0] s0_s1;
	logic signed [PBits-1:0] p1_s2, p2_s3, p3_s4, p4_s5;
	logic [RBits-1:0] s_s2, s_s3;
	always_ff @(posedge clk) begin
		s0_s1 <= RBits'((rr + (1 << (RatioBits - 1))) >> RatioBits);
		s_s2 <= s0_s1;
		s_s3 <= s_s2;
		p1_s2 <= mul_round(CoefC5, s0_s1) + CoefC3;
		p2_s3 <= mul_round(p1_s2, s_s2) + CoefC1;
		p3_s4 <= mul_round(p2_s3, s_s3);
		p4_s5 <= mul_round(p3_s4, r_q[3]);
	end
	assign p_q = p4_s5;

	// Octant folding and final rounding.
	localparam int RootAt = PolyStart - DivStart + 5;
	always_comb begin
		fold_t f;
		f = fold_q[RootAt];
		f0 = AccBits'(p_q) + (AccBits'(r_q[4]) <<< (PolyFrac - RatioBits));
		f1 = f.swap ? HalfPi - f0 : f0;
		f2 = f.xneg ? Pi - f1 : f1;
		f3 = f.yneg ? -f2 : f2;
	end
	always_ff @(posedge clk) a_q <= f3;
	always_comb begin
		logic signed [AccBits-1:0] m;
		m = a_q[AccBits-1] ? -a_q : a_q;
		m = (m + (AccBits'(1) <<< (PolyFrac - AngleFracBits - 1))) >>> (PolyFrac - AngleFracBits);
		arnd = a_q[AccBits-1] ? -m : m;
	end
	always_ff @(posedge clk) begin
		ang_q <= fold_q[RootAt+1].zero ? '0 :
			(arnd > 36'sd32767) ? 16'sd32767 :
			(arnd < -36'sd32768) ? -16'sd32768 : 16'(arnd);
		mag_q <= (root_q[RootAt] > RootBits'(16'hFFFF)) ? 16'hFFFF
			: root_q[RootAt][15:0];
	end
	assign done = vld_q[Depth-1];
	assign result = '{magnitude: mag_q, angle: ang_q};

	`ASSERT_SAME(a_busy_low, clk, arst_n, 1'b1, !busy)
	`ASSERT_SAME(a_zero_ang, clk, arst_n, done && result.magnitude == '0, result.angle == '0)
endmodule
